### sv/fragment_reassembly_slots_unit_macros.svh
// Assertion macros for the fragment reassembly slots unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef FRAGMENT_REASSEMBLY_SLOTS_UNIT_MACROS_SVH
`define FRAGMENT_REASSEMBLY_SLOTS_UNIT_MACROS_SVH

// Same-cycle implication
`define FRSU_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FRSU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/frsu_pkg.sv
// Shared types and constants of the fragment reassembly slots unit.
// No dependencies.
`default_nettype none
package frsu_pkg;

    localparam int SLOT_BYTES  = 64;
    localparam int IDX_W       = $clog2(SLOT_BYTES);
    localparam int FILL_W      = $clog2(SLOT_BYTES + 1);
    localparam int SLOT_ID_W   = 3;
    localparam int KEY_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int KIND_W      = 2;
    localparam int SLOT_OUT_W  = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd3;

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef struct packed {
        logic                  stream;
        logic [KIND_W-1:0]     kind;
        logic [SLOT_ID_W-1:0]  slot;
        logic                  evicted;
        logic [FILL_W-1:0]     fill;
    } t_cmd;

endpackage
`default_nettype wire

### sv/frsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module frsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/frsu_fifo.sv
// Short command queue between the front and back parts.
// Depends on frsu_pkg.
`default_nettype none
module frsu_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire frsu_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output frsu_pkg::t_cmd      o_cmd,
    output logic                o_empty,
    output logic                o_full
);
    import frsu_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### sv/frsu_front.sv
// Front part: accepts items, keeps slot table and fragment state, writes payload
// bytes into the byte RAM and queues one command per item that yields results.
// Depends on frsu_pkg.
`default_nettype none
module frsu_front #(
    parameter int NUM_SLOTS = 3,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int ADDR_W = SW + frsu_pkg::IDX_W
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_operation,
    input  wire logic [frsu_pkg::KEY_W-1:0]    i_key,
    input  wire logic [frsu_pkg::LEN_W-1:0]    i_fragment_length,
    input  wire logic [frsu_pkg::LEN_W-1:0]    i_expected_length,
    input  wire logic [frsu_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_q_full,
    input  wire logic                          i_stream_done,
    output logic                               o_push,
    output frsu_pkg::t_cmd                     o_cmd,
    output logic                               o_we,
    output logic [ADDR_W-1:0]                  o_waddr,
    output logic [frsu_pkg::BYTE_W-1:0]        o_wdata
);
    import frsu_pkg::*;

    logic              r_busy [NUM_SLOTS];
    logic              n_busy [NUM_SLOTS];
    logic [KEY_W-1:0]  r_key  [NUM_SLOTS];
    logic [KEY_W-1:0]  n_key  [NUM_SLOTS];
    logic [FILL_W-1:0] r_fill [NUM_SLOTS];
    logic [FILL_W-1:0] n_fill [NUM_SLOTS];
    logic [SW-1:0]     r_active, n_active;
    logic              r_frag, n_frag;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [LEN_W-1:0]  r_target, n_target;
    logic              r_hold, n_hold;

    logic              accept;
    logic              hit_found;
    logic [SW-1:0]     hit_slot;
    logic              free_found;
    logic [SW-1:0]     free_slot;
    logic [SW-1:0]     hdr_slot;
    logic              hdr_new;
    logic              hdr_ev;
    logic [SW-1:0]     rd_slot;
    logic [FILL_W-1:0] fill_rd;
    logic [FILL_W-1:0] hdr_fill;
    logic [LEN_W:0]    hdr_sum;
    logic              hdr_over;
    logic              pay_wr;
    logic [FILL_W-1:0] pay_fill;
    logic [LEN_W-1:0]  rem_next;

    assign o_stall = i_q_full || r_hold;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        hit_found  = 1'b0;
        hit_slot   = '0;
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_busy[i] && (r_key[i] == i_key)) begin
                hit_found = 1'b1;
                hit_slot  = SW'(i);
            end
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
        if (hit_found) begin
            hdr_slot = hit_slot;
            hdr_new  = 1'b0;
            hdr_ev   = 1'b0;
        end else if (free_found) begin
            hdr_slot = free_slot;
            hdr_new  = 1'b1;
            hdr_ev   = 1'b0;
        end else begin
            hdr_slot = '0;
            hdr_new  = 1'b1;
            hdr_ev   = 1'b1;
        end
    end

    assign rd_slot  = (i_operation == OP_HEADER) ? hdr_slot : r_active;
    assign fill_rd  = r_fill[rd_slot];
    assign hdr_fill = hdr_new ? '0 : fill_rd;
    assign hdr_sum  = (LEN_W + 1)'(hdr_fill) + (LEN_W + 1)'(i_fragment_length);
    assign hdr_over = hdr_sum > (LEN_W + 1)'(SLOT_BYTES);
    assign pay_wr   = fill_rd < FILL_W'(SLOT_BYTES);
    assign pay_fill = pay_wr ? fill_rd + 1'b1 : fill_rd;
    assign rem_next = (r_rem != '0) ? r_rem - 1'b1 : '0;

    assign o_waddr = {r_active, fill_rd[IDX_W-1:0]};
    assign o_wdata = i_data_byte;

    always_comb begin
        n_busy   = r_busy;
        n_key    = r_key;
        n_fill   = r_fill;
        n_active = r_active;
        n_frag   = r_frag;
        n_rem    = r_rem;
        n_target = r_target;
        n_hold   = r_hold;
        o_push   = 1'b0;
        o_we     = 1'b0;
        o_cmd    = '0;
        if (i_stream_done) begin
            n_hold = 1'b0;
        end
        if (accept) begin
            if (i_operation == OP_HEADER) begin
                n_frag      = 1'b0;
                o_push      = 1'b1;
                o_cmd.slot  = SLOT_ID_W'(hdr_slot);
                o_cmd.evicted = hdr_ev;
                o_cmd.fill  = hdr_fill;
                n_key[hdr_slot]  = i_key;
                n_fill[hdr_slot] = hdr_fill;
                if (hdr_over) begin
                    n_busy[hdr_slot] = 1'b0;
                    o_cmd.kind       = KIND_OVERFLOW;
                end else begin
                    n_busy[hdr_slot] = 1'b1;
                    n_active         = hdr_slot;
                    n_target         = i_expected_length;
                    n_rem            = i_fragment_length;
                    o_cmd.kind       = KIND_ACCEPT;
                    if (i_fragment_length == '0) begin
                        if (LEN_W'(hdr_fill) >= i_expected_length) begin
                            n_busy[hdr_slot] = 1'b0;
                            if (hdr_fill == '0) begin
                                o_cmd.kind = KIND_EMPTY;
                            end else begin
                                o_cmd.kind   = KIND_BYTE;
                                o_cmd.stream = 1'b1;
                                n_hold       = 1'b1;
                            end
                        end
                    end else begin
                        n_frag = 1'b1;
                    end
                end
            end else if (r_frag) begin
                o_we               = pay_wr;
                n_fill[r_active]   = pay_fill;
                n_rem              = rem_next;
                o_push             = 1'b1;
                o_cmd.slot         = SLOT_ID_W'(r_active);
                o_cmd.fill         = pay_fill;
                o_cmd.kind         = KIND_ACCEPT;
                if (rem_next == '0) begin
                    n_frag = 1'b0;
                    if (LEN_W'(pay_fill) >= r_target) begin
                        n_busy[r_active] = 1'b0;
                        if (pay_fill == '0) begin
                            o_cmd.kind = KIND_EMPTY;
                        end else begin
                            o_cmd.kind   = KIND_BYTE;
                            o_cmd.stream = 1'b1;
                            n_hold       = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_busy[i] <= 1'b0;
            end
            r_active <= '0;
            r_frag   <= 1'b0;
            r_rem    <= '0;
            r_target <= '0;
            r_hold   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_active <= n_active;
            r_frag   <= n_frag;
            r_rem    <= n_rem;
            r_target <= n_target;
            r_hold   <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_fill <= n_fill;
    end

endmodule
`default_nettype wire

### sv/frsu_back.sv
// Back part: takes queued commands, drives the result register and streams
// assembled messages out of the byte RAM one byte per cycle while i_stall is low.
// Depends on frsu_pkg.
`default_nettype none
module frsu_back #(
    parameter int NUM_SLOTS = 3,
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int ADDR_W = SW + frsu_pkg::IDX_W
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_empty,
    input  wire frsu_pkg::t_cmd                  i_cmd,
    output logic                                 o_pop,
    output logic                                 o_re,
    output logic [ADDR_W-1:0]                    o_raddr,
    input  wire logic [frsu_pkg::BYTE_W-1:0]     i_rdata,
    output logic                                 o_stream_done,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [frsu_pkg::KIND_W-1:0]          o_kind,
    output logic [frsu_pkg::BYTE_W-1:0]          o_data_out,
    output logic [frsu_pkg::IDX_W-1:0]           o_byte_index,
    output logic [frsu_pkg::SLOT_OUT_W-1:0]      o_slot_used,
    output logic                                 o_evicted,
    output logic [frsu_pkg::FILL_W-1:0]          o_fill_level,
    output logic                                 o_last
);
    import frsu_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic              r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SW-1:0]     r_slot, n_slot;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_ev, n_ev;

    logic              r_valid, n_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [BYTE_W-1:0] r_data, n_data;
    logic [IDX_W-1:0]  r_bidx, n_bidx;
    logic [SLOT_OUT_W-1:0] r_oslot, n_oslot;
    logic              r_oev, n_oev;
    logic [FILL_W-1:0] r_ofill, n_ofill;
    logic              r_last, n_last;

    logic              out_free;
    logic              is_last;

    assign out_free = !r_valid || !i_stall;
    assign is_last  = (FILL_W'(r_idx) + 1'b1) == r_fill;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_slot        = r_slot;
        n_fill        = r_fill;
        n_ev          = r_ev;
        n_valid       = out_free ? 1'b0 : r_valid;
        n_kind        = r_kind;
        n_data        = r_data;
        n_bidx        = r_bidx;
        n_oslot       = r_oslot;
        n_oev         = r_oev;
        n_ofill       = r_ofill;
        n_last        = r_last;
        o_pop         = 1'b0;
        o_re          = 1'b0;
        o_raddr       = {SW'(i_cmd.slot), {IDX_W{1'b0}}};
        o_stream_done = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.stream) begin
                        o_pop   = 1'b1;
                        o_re    = 1'b1;
                        n_state = ST_STREAM;
                        n_idx   = '0;
                        n_slot  = SW'(i_cmd.slot);
                        n_fill  = i_cmd.fill;
                        n_ev    = i_cmd.evicted;
                    end else if (out_free) begin
                        o_pop   = 1'b1;
                        n_valid = 1'b1;
                        n_kind  = i_cmd.kind;
                        n_data  = '0;
                        n_bidx  = '0;
                        n_oslot = SLOT_OUT_W'(i_cmd.slot);
                        n_oev   = i_cmd.evicted;
                        n_ofill = i_cmd.fill;
                        n_last  = 1'b1;
                    end
                end
            end
            ST_STREAM: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_BYTE;
                    n_data  = i_rdata;
                    n_bidx  = r_idx;
                    n_oslot = SLOT_OUT_W'(r_slot);
                    n_oev   = r_ev;
                    n_ofill = r_fill;
                    n_last  = is_last;
                    if (is_last) begin
                        n_state       = ST_IDLE;
                        o_stream_done = 1'b1;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = {r_slot, r_idx + 1'b1};
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_fill  <= n_fill;
        r_ev    <= n_ev;
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_bidx  <= n_bidx;
        r_oslot <= n_oslot;
        r_oev   <= n_oev;
        r_ofill <= n_ofill;
        r_last  <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_data_out   = r_data;
    assign o_byte_index = r_bidx;
    assign o_slot_used  = r_oslot;
    assign o_evicted    = r_oev;
    assign o_fill_level = r_ofill;
    assign o_last       = r_last;

endmodule
`default_nettype wire

### sv/fragment_reassembly_slots_unit.sv
// A header, or a payload byte of an open fragment, that completes no message gives one
// result via the command queue and result register; an assembled message passes the
// queue, byte RAM read register and result register, then streams one byte per cycle
// while i_stall is low, set by the byte RAM's read port. Throughput: one item per
// cycle while o_stall is low; a byte completion stalls input until its message is out.
// Reset (synchronous, active low) frees all slots and empties the queue.
`default_nettype none
module fragment_reassembly_slots_unit #(
    parameter int NUM_SLOTS = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_operation,
    input  wire logic [frsu_pkg::KEY_W-1:0]      i_key,
    input  wire logic [frsu_pkg::LEN_W-1:0]      i_fragment_length,
    input  wire logic [frsu_pkg::LEN_W-1:0]      i_expected_length,
    input  wire logic [frsu_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [frsu_pkg::KIND_W-1:0]          o_kind,
    output logic [frsu_pkg::BYTE_W-1:0]          o_data_out,
    output logic [frsu_pkg::IDX_W-1:0]           o_byte_index,
    output logic [frsu_pkg::SLOT_OUT_W-1:0]      o_slot_used,
    output logic                                 o_evicted,
    output logic [frsu_pkg::FILL_W-1:0]          o_fill_level,
    output logic                                 o_last
);
    import frsu_pkg::*;

    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ADDR_W    = SW + IDX_W;
    localparam int RAM_DEPTH = NUM_SLOTS * SLOT_BYTES;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    t_cmd              push_cmd;
    t_cmd              head_cmd;
    logic              push;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              stream_done;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] rdata;

    frsu_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_key             (i_key),
        .i_fragment_length (i_fragment_length),
        .i_expected_length (i_expected_length),
        .i_data_byte       (i_data_byte),
        .i_q_full          (q_full),
        .i_stream_done     (stream_done),
        .o_push            (push),
        .o_cmd             (push_cmd),
        .o_we              (we),
        .o_waddr           (waddr),
        .o_wdata           (wdata)
    );

    frsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    frsu_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (RAM_AW'(waddr)),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (RAM_AW'(raddr)),
        .o_rdata (rdata)
    );

    frsu_back #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_re          (re),
        .o_raddr       (raddr),
        .i_rdata       (rdata),
        .o_stream_done (stream_done),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data_out    (o_data_out),
        .o_byte_index  (o_byte_index),
        .o_slot_used   (o_slot_used),
        .o_evicted     (o_evicted),
        .o_fill_level  (o_fill_level),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

### sv/frsu_checker.sv
// Port-level checker for the fragment reassembly slots unit, bound to the top.
// Depends on frsu_pkg and fragment_reassembly_slots_unit_macros.svh.
`default_nettype none
`include "fragment_reassembly_slots_unit_macros.svh"
module frsu_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            o_valid,
    input  wire logic                            i_stall,
    input  wire logic [frsu_pkg::KIND_W-1:0]     o_kind,
    input  wire logic [frsu_pkg::BYTE_W-1:0]     o_data_out,
    input  wire logic [frsu_pkg::IDX_W-1:0]      o_byte_index,
    input  wire logic [frsu_pkg::SLOT_OUT_W-1:0] o_slot_used,
    input  wire logic                            o_evicted,
    input  wire logic [frsu_pkg::FILL_W-1:0]     o_fill_level,
    input  wire logic                            o_last
);
    import frsu_pkg::*;

    `FRSU_ASSERT_IMP(a_single_last, o_valid && o_kind != KIND_BYTE, o_last,
        "non-byte result not marked last")

    `FRSU_ASSERT_IMP(a_single_zero, o_valid && o_kind != KIND_BYTE,
        o_data_out == '0 && o_byte_index == '0, "non-byte result carries data")

    `FRSU_ASSERT_IMP(a_fill_range, o_valid, o_fill_level <= FILL_W'(SLOT_BYTES),
        "fill level beyond slot size")

    `FRSU_ASSERT_NEXT(a_byte_run, o_valid && !i_stall && o_kind == KIND_BYTE && !o_last,
        o_valid && o_kind == KIND_BYTE && o_byte_index == $past(o_byte_index) + 1'b1,
        "assembled bytes not contiguous")

    `FRSU_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_kind) && $stable(o_data_out) && $stable(o_byte_index)
        && $stable(o_slot_used) && $stable(o_evicted) && $stable(o_fill_level)
        && $stable(o_last),
        "stalled result changed")

endmodule

bind fragment_reassembly_slots_unit frsu_checker u_frsu_checker (.*);
`default_nettype wire

### tb/fragment_reassembly_slots_unit_test.sv
// Self-checking testbench for the fragment reassembly slots unit: directed and
// random fragment traffic, checked against a built-in slot reassembly predictor.
// Depends on frsu_pkg and fragment_reassembly_slots_unit.
`timescale 1ns / 100ps
module fragment_reassembly_slots_unit_test;
    import frsu_pkg::*;

    localparam int SLOTS = 3;
    localparam int KEYS  = 6;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [BYTE_W-1:0]     data;
        logic [IDX_W-1:0]      idx;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [FILL_W-1:0]     fill;
        logic                  last;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_operation = OP_HEADER;
    logic [KEY_W-1:0]      i_key = '0;
    logic [LEN_W-1:0]      i_fragment_length = '0;
    logic [LEN_W-1:0]      i_expected_length = '0;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic [BYTE_W-1:0]     o_data_out;
    logic [IDX_W-1:0]      o_byte_index;
    logic [SLOT_OUT_W-1:0] o_slot_used;
    logic                  o_evicted;
    logic [FILL_W-1:0]     o_fill_level;
    logic                  o_last;

    t_result               pending_results [$];
    int                    mismatch_count = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_request = 0;
    int                    hold_left = 0;
    int                    traffic_items = 0;
    logic [KEY_W-1:0]      key_pool [KEYS];

    bit                    slot_taken [SLOTS] = '{default: 1'b0};
    logic [KEY_W-1:0]      slot_tag [SLOTS];
    int                    slot_level [SLOTS];
    logic [BYTE_W-1:0]     slot_data [SLOTS][SLOT_BYTES];
    int                    cur_slot = 0;
    bit                    frag_open = 1'b0;
    int                    left_bytes = 0;
    int                    want_len = 0;

    fragment_reassembly_slots_unit #(.NUM_SLOTS(SLOTS)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_key             (i_key),
        .i_fragment_length (i_fragment_length),
        .i_expected_length (i_expected_length),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_data_out        (o_data_out),
        .o_byte_index      (o_byte_index),
        .o_slot_used       (o_slot_used),
        .o_evicted         (o_evicted),
        .o_fill_level      (o_fill_level),
        .o_last            (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void push_result(input logic [KIND_W-1:0] kind, input int data,
                                        input int idx, input int slot, input bit ev,
                                        input int fill, input bit last);
        t_result r;
        r.kind    = kind;
        r.data    = BYTE_W'(data);
        r.idx     = IDX_W'(idx);
        r.slot    = SLOT_OUT_W'(slot);
        r.evicted = ev;
        r.fill    = FILL_W'(fill);
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    function automatic bit release_message(input int s, input bit ev);
        int i;
        if (slot_level[s] < want_len)
            return 1'b0;
        slot_taken[s] = 1'b0;
        if (slot_level[s] == 0)
            push_result(KIND_EMPTY, 0, 0, s, ev, 0, 1'b1);
        for (i = 0; i < slot_level[s]; i++)
            push_result(KIND_BYTE, int'(slot_data[s][i]), i, s, ev, slot_level[s],
                        i + 1 == slot_level[s]);
        return 1'b1;
    endfunction

    task automatic reassemble_item(input logic op, input logic [KEY_W-1:0] key,
                                   input logic [LEN_W-1:0] flen,
                                   input logic [LEN_W-1:0] elen,
                                   input logic [BYTE_W-1:0] data);
        int s;
        int i;
        bit ev;
        s  = -1;
        ev = 1'b0;
        if (op == OP_HEADER) begin
            frag_open = 1'b0;
            for (i = 0; i < SLOTS; i++)
                if (s < 0 && slot_taken[i] && slot_tag[i] == key)
                    s = i;
            if (s < 0) begin
                for (i = 0; i < SLOTS; i++)
                    if (s < 0 && !slot_taken[i])
                        s = i;
                if (s < 0) begin
                    s  = 0;
                    ev = 1'b1;
                end
                slot_taken[s] = 1'b1;
                slot_tag[s]   = key;
                slot_level[s] = 0;
            end
            if (slot_level[s] + int'(flen) > SLOT_BYTES) begin
                slot_taken[s] = 1'b0;
                push_result(KIND_OVERFLOW, 0, 0, s, ev, slot_level[s], 1'b1);
            end else begin
                cur_slot   = s;
                want_len   = int'(elen);
                left_bytes = int'(flen);
                if (flen != 0)
                    frag_open = 1'b1;
                if (flen != 0 || !release_message(s, ev))
                    push_result(KIND_ACCEPT, 0, 0, s, ev, slot_level[s], 1'b1);
            end
        end else if (frag_open) begin
            s = cur_slot;
            if (slot_level[s] < SLOT_BYTES) begin
                slot_data[s][slot_level[s]] = data;
                slot_level[s]++;
            end
            if (left_bytes > 0)
                left_bytes--;
            if (left_bytes == 0)
                frag_open = 1'b0;
            if (left_bytes != 0 || !release_message(s, 1'b0))
                push_result(KIND_ACCEPT, 0, 0, s, 1'b0, slot_level[s], 1'b1);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            reassemble_item(i_operation, i_key, i_fragment_length, i_expected_length,
                            i_data_byte);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, kind", int'(o_kind), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", int'(o_kind), int'(want.kind));
                if (o_data_out !== want.data)
                    report_mismatch("data_out", int'(o_data_out), int'(want.data));
                if (o_byte_index !== want.idx)
                    report_mismatch("byte_index", int'(o_byte_index), int'(want.idx));
                if (o_slot_used !== want.slot)
                    report_mismatch("slot_used", int'(o_slot_used), int'(want.slot));
                if (o_evicted !== want.evicted)
                    report_mismatch("evicted", int'(o_evicted), int'(want.evicted));
                if (o_fill_level !== want.fill)
                    report_mismatch("fill_level", int'(o_fill_level), int'(want.fill));
                if (o_last !== want.last)
                    report_mismatch("last", int'(o_last), int'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [LEN_W-1:0] flen, input logic [LEN_W-1:0] elen,
                             input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_operation       <= op;
        i_key             <= key;
        i_fragment_length <= flen;
        i_expected_length <= elen;
        i_data_byte       <= data;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic send_header(input logic [KEY_W-1:0] key, input int flen, input int elen);
        send_item(OP_HEADER, key, LEN_W'(flen), LEN_W'(elen), BYTE_W'($urandom));
        traffic_items++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] data);
        send_item(OP_PAYLOAD, KEY_W'($urandom), LEN_W'($urandom), LEN_W'($urandom), data);
        traffic_items++;
    endtask

    task automatic wait_for_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_single_message;
        send_header(24'hFFFFFF, 3, 3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        wait_for_results;
    endtask

    task automatic test_empty_message;
        send_header(24'h000000, 0, 0);
        wait_for_results;
    endtask

    task automatic test_stray_payload;
        send_item(OP_PAYLOAD, 24'h000000, 8'd0, 8'd0, 8'h5A);
        wait_for_results;
    endtask

    task automatic test_overflow;
        send_header(24'h5A5A5A, 255, 0);
        send_header(24'hA5A5A5, 5, 5);
        send_byte(8'h11);
        send_byte(8'h22);
        send_header(24'hA5A5A5, 63, 5);
        wait_for_results;
    endtask

    task automatic test_abandoned_fragment;
        send_header(24'h0F0F0F, 4, 6);
        send_byte(8'h01);
        send_byte(8'h80);
        send_header(24'h0F0F0F, 4, 6);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h3C);
        send_byte(8'hC3);
        wait_for_results;
    endtask

    task automatic test_slot_eviction;
        send_header(24'h800000, 1, 9);
        send_header(24'h00FF00, 1, 9);
        send_header(24'h123456, 1, 9);
        send_header(24'hFEDCBA, 0, 0);
        wait_for_results;
    endtask

    task automatic test_zero_length_open;
        send_header(24'h00FF00, 0, 255);
        wait_for_results;
    endtask

    task automatic test_backpressure;
        int f;
        int i;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 400;
        for (f = 0; f < 4; f++) begin
            send_header(24'hC0FFEE, 16, SLOT_BYTES);
            for (i = 0; i < 16; i++)
                send_byte(BYTE_W'($urandom));
        end
        for (i = 0; i < 6; i++) begin
            send_header(key_pool[i], 2, 2);
            send_byte(BYTE_W'($urandom));
            send_byte(BYTE_W'($urandom));
        end
        wait_for_results;
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int count);
        int start;
        int r;
        int k;
        int total;
        int left;
        int flen;
        logic [KEY_W-1:0] key;
        idle_pct  = idle;
        stall_pct = stall;
        start     = traffic_items;
        while (traffic_items - start < count) begin
            r = $urandom_range(99);
            k = $urandom_range(KEYS - 1);
            if ($urandom_range(9) == 0)
                key_pool[k] = KEY_W'($urandom);
            key = key_pool[k];
            if (r < 70) begin
                total = ($urandom_range(9) == 0) ? $urandom_range(13, SLOT_BYTES)
                                                 : $urandom_range(0, 12);
                left  = total;
                do begin
                    flen = $urandom_range(1, 8);
                    if (flen > left)
                        flen = left;
                    send_header(key, flen, total);
                    repeat (flen) send_byte(BYTE_W'($urandom));
                    left -= flen;
                end while (left > 0);
            end else if (r < 82) begin
                send_header(KEY_W'($urandom), $urandom_range(255), $urandom_range(255));
            end else if (r < 90) begin
                send_byte(BYTE_W'($urandom));
            end else begin
                flen = $urandom_range(2, 10);
                send_header(key, flen, $urandom_range(0, 20));
                repeat ($urandom_range(flen - 1)) send_byte(BYTE_W'($urandom));
            end
        end
        wait_for_results;
    endtask

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        foreach (key_pool[k])
            key_pool[k] = KEY_W'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_message;
        test_empty_message;
        test_stray_payload;
        test_overflow;
        test_abandoned_fragment;
        test_slot_eviction;
        test_zero_length_open;
        test_backpressure;
        test_random_traffic(0, 0, 30);
        test_random_traffic(48, 0, 30);
        test_random_traffic(0, 48, 30);
        test_random_traffic(20, 20, 30);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
